// File: rtl/cppt_pkg.sv
package cppt_pkg;

	// operation codes
	localparam logic [2:0] OP_CLEAR = 3'd0;
	localparam logic [2:0] OP_ADD   = 3'd1;
	localparam logic [2:0] OP_CHECK = 3'd2;
	localparam logic [2:0] OP_TEST  = 3'd3;
	localparam logic [2:0] OP_SCALE = 3'd4;

	// status codes
	localparam logic [2:0] STS_OK          = 3'd0;
	localparam logic [2:0] STS_FULL        = 3'd1;
	localparam logic [2:0] STS_TOO_FEW     = 3'd2;
	localparam logic [2:0] STS_NOT_CONVEX  = 3'd3;
	localparam logic [2:0] STS_NOT_CHECKED = 3'd4;
	localparam logic [2:0] STS_ZERO_FACTOR = 3'd5;

	// request payload
	typedef struct packed {
		logic [2:0]         operation;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic signed [15:0] scale_factor;
	} req_t;

	// response payload
	typedef struct packed {
		logic [2:0]         status;
		logic               inside_res;
		logic signed [15:0] box_min_x;
		logic signed [15:0] box_min_y;
		logic [16:0]        box_width;
		logic [16:0]        box_height;
		logic [4:0]         stored_count;
	} rsp_t;

	// sign flags from the cross product unit
	typedef struct packed {
		logic vld;
		logic last;
		logic pos;
		logic neg;
	} cross_flags_t;

endpackage

// File: rtl/convex_polygon_point_test_core.sv
// check and test: walk over n vertices with n + 2 memory reads
// scale: n vertex reads, one per cycle, each written back after the read data and product registers
// clear, add, scale with no vertices and the rejected cases: result registered in the cycle after the transfer
// one operation at a time; the next is taken once the result slot can drain
// reset clears the vertex count, the checked flag and all control; vertex memory is not cleared
module convex_polygon_point_test_core #(
	parameter int MAX_VERTICES = 16,
	parameter int COORD_BITS   = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cppt_pkg::req_t req,
	input  logic           req_valid,
	output logic           req_stall,
	output cppt_pkg::rsp_t rsp,
	output logic           rsp_valid,
	input  logic           rsp_stall
);
	import cppt_pkg::*;

	localparam int CW  = COORD_BITS;
	localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int NW  = $clog2(MAX_VERTICES + 1);
	localparam int PW  = NW + 1;
	localparam int MX  = (CW > 16) ? CW : 16;
	localparam int DW  = MX + 1;
	localparam int PRW = CW + 16;
	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_WALK  = 4'b0010,
		S_SCALE = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t               state_q;
	logic [NW-1:0]        count_q;
	logic                 checked_q, is_check_q, is_scale_q;
	logic signed [15:0]   px_q, py_q, f_q;
	logic [PW-1:0]        pos_q, pos_s1;
	logic                 vld_s1;
	logic [AW-1:0]        addr_s1, addr_s2;
	logic                 vld_s2, last_s2;
	logic signed [PRW-1:0] prod_x_s2, prod_y_s2;
	logic signed [CW-1:0] xa_q, ya_q, xb_q, yb_q;
	logic signed [CW-1:0] minx_q, maxx_q, miny_q, maxy_q;
	logic                 pos_seen_q, neg_seen_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	logic                 accept, slot_free, imm_load, fin_load, load;
	logic                 issue, mem_we;
	logic [PW-1:0]        n_p, limit;
	logic [AW-1:0]        raddr, waddr;
	logic signed [CW-1:0] rd_x, rd_y, wd_x, wd_y, add_x, add_y, sc_x, sc_y;
	logic signed [MX-1:0] in_x_w, in_y_w;
	logic signed [PRW-1:0] q_x, q_y;
	logic                 diff_vld, diff_last;
	logic signed [DW-1:0] dx1, dy1, dx2, dy2;
	cross_flags_t         flags;
	logic [NW-1:0]        count_d;
	logic                 checked_d;
	rsp_t                 res_imm, res_fin;
	logic [CW:0]          wx, hy;

	// handshake
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE) || !slot_free;
	assign accept    = req_valid && !req_stall;
	assign n_p       = PW'(count_q);

	// immediate operations and walk launch decision
	always_comb begin
		count_d   = count_q;
		checked_d = checked_q;
		res_imm   = '0;
		imm_load  = 1'b1;
		case (req.operation)
			OP_CLEAR: begin
				count_d   = '0;
				checked_d = 1'b0;
			end
			OP_ADD: begin
				if (count_q >= NW'(MAX_VERTICES)) begin
					res_imm.status = STS_FULL;
				end else begin
					count_d   = count_q + NW'(1);
					checked_d = 1'b0;
				end
			end
			OP_CHECK: begin
				if (count_q < NW'(3)) begin
					res_imm.status = STS_TOO_FEW;
					checked_d      = 1'b0;
				end else begin
					imm_load = 1'b0;
				end
			end
			OP_TEST: begin
				if (!checked_q || count_q < NW'(3)) begin
					res_imm.status = STS_NOT_CHECKED;
				end else begin
					imm_load = 1'b0;
				end
			end
			OP_SCALE: begin
				if (req.scale_factor == 16'sd0) begin
					res_imm.status = STS_ZERO_FACTOR;
				end else if (count_q != '0) begin
					imm_load = 1'b0;
				end
			end
			default: begin
			end
		endcase
		res_imm.stored_count = 5'(count_d);
	end

	// saturate an added vertex to the stored width
	always_comb begin
		in_x_w = MX'(req.coord_x);
		in_y_w = MX'(req.coord_y);
		if (in_x_w > MX'(CMAX)) begin
			add_x = CMAX;
		end else if (in_x_w < MX'(CMIN)) begin
			add_x = CMIN;
		end else begin
			add_x = CW'(in_x_w);
		end
		if (in_y_w > MX'(CMAX)) begin
			add_y = CMAX;
		end else if (in_y_w < MX'(CMIN)) begin
			add_y = CMIN;
		end else begin
			add_y = CW'(in_y_w);
		end
	end

	// read issue: walks read n + 2 positions wrapping to the start, scale reads n
	assign limit = is_scale_q ? n_p : n_p + PW'(2);
	assign issue = (state_q == S_WALK || state_q == S_SCALE) && (pos_q < limit);
	assign raddr = (pos_q < n_p) ? AW'(pos_q) : AW'(pos_q - n_p);

	// floor and saturate the scaled vertex
	always_comb begin
		q_x = prod_x_s2 >>> 8;
		q_y = prod_y_s2 >>> 8;
		if (q_x > PRW'(CMAX)) begin
			sc_x = CMAX;
		end else if (q_x < PRW'(CMIN)) begin
			sc_x = CMIN;
		end else begin
			sc_x = CW'(q_x);
		end
		if (q_y > PRW'(CMAX)) begin
			sc_y = CMAX;
		end else if (q_y < PRW'(CMIN)) begin
			sc_y = CMIN;
		end else begin
			sc_y = CW'(q_y);
		end
	end

	// write port shared by add and scale write-back
	always_comb begin
		mem_we = vld_s2;
		waddr  = addr_s2;
		wd_x   = sc_x;
		wd_y   = sc_y;
		if (accept && req.operation == OP_ADD && count_q < NW'(MAX_VERTICES)) begin
			mem_we = 1'b1;
			waddr  = AW'(count_q);
			wd_x   = add_x;
			wd_y   = add_y;
		end
	end

	cppt_vtx_mem #(
		.DEPTH (MAX_VERTICES),
		.AW    (AW),
		.W     (CW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (waddr),
		.wdata_x (wd_x),
		.wdata_y (wd_y),
		.re      (issue),
		.raddr   (raddr),
		.rdata_x (rd_x),
		.rdata_y (rd_y)
	);

	// edge vectors from the vertex window
	assign diff_vld  = vld_s1 && !is_scale_q && (pos_s1 >= PW'(2));
	assign diff_last = (pos_s1 == n_p + PW'(1));
	assign dx1 = DW'(xb_q) - DW'(xa_q);
	assign dy1 = DW'(yb_q) - DW'(ya_q);
	assign dx2 = is_check_q ? DW'(rd_x) - DW'(xb_q) : DW'(px_q) - DW'(xa_q);
	assign dy2 = is_check_q ? DW'(rd_y) - DW'(yb_q) : DW'(py_q) - DW'(ya_q);

	cppt_cross #(
		.DW (DW)
	) u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (diff_vld),
		.last   (diff_last),
		.a      (dx1),
		.b      (dy2),
		.c      (dy1),
		.d      (dx2),
		.flags  (flags)
	);

	// final result of a walk or scale
	always_comb begin
		res_fin              = '0;
		res_fin.stored_count = 5'(count_q);
		wx                   = (CW+1)'(maxx_q) - (CW+1)'(minx_q) + (CW+1)'(1);
		hy                   = (CW+1)'(maxy_q) - (CW+1)'(miny_q) + (CW+1)'(1);
		if (!is_scale_q) begin
			if (is_check_q) begin
				if (pos_seen_q && neg_seen_q) begin
					res_fin.status = STS_NOT_CONVEX;
				end else begin
					res_fin.box_min_x  = 16'(minx_q);
					res_fin.box_min_y  = 16'(miny_q);
					res_fin.box_width  = 17'(wx);
					res_fin.box_height = 17'(hy);
				end
			end else begin
				res_fin.inside_res = !(pos_seen_q && neg_seen_q);
			end
		end
	end

	assign fin_load = (state_q == S_FIN) && slot_free;
	assign load     = (accept && imm_load) || fin_load;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			checked_q   <= 1'b0;
			is_check_q  <= 1'b0;
			is_scale_q  <= 1'b0;
			pos_q       <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			last_s2     <= 1'b0;
			pos_seen_q  <= 1'b0;
			neg_seen_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			vld_s1  <= issue;
			vld_s2  <= vld_s1 && is_scale_q;
			last_s2 <= vld_s1 && is_scale_q && (pos_s1 == n_p - PW'(1));
			if (issue) begin
				pos_q <= pos_q + PW'(1);
			end
			if (flags.vld) begin
				pos_seen_q <= pos_seen_q | flags.pos;
				neg_seen_q <= neg_seen_q | flags.neg;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q    <= count_d;
						checked_q  <= checked_d;
						is_check_q <= (req.operation == OP_CHECK);
						is_scale_q <= (req.operation == OP_SCALE);
						pos_q      <= '0;
						pos_seen_q <= 1'b0;
						neg_seen_q <= 1'b0;
						if (!imm_load) begin
							state_q <= (req.operation == OP_SCALE) ? S_SCALE : S_WALK;
						end
					end
				end
				S_WALK: begin
					if (flags.vld && flags.last) begin
						state_q <= S_FIN;
					end
				end
				S_SCALE: begin
					if (vld_s2 && last_s2) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
						if (is_check_q) begin
							checked_q <= !(pos_seen_q && neg_seen_q);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= req.coord_x;
			py_q <= req.coord_y;
			f_q  <= req.scale_factor;
		end
		pos_s1  <= pos_q;
		addr_s1 <= raddr;
		addr_s2 <= addr_s1;
		prod_x_s2 <= PRW'(rd_x) * PRW'(f_q);
		prod_y_s2 <= PRW'(rd_y) * PRW'(f_q);
		// sliding window and bounding box
		if (vld_s1) begin
			xa_q <= xb_q;
			ya_q <= yb_q;
			xb_q <= rd_x;
			yb_q <= rd_y;
			if (pos_s1 == '0) begin
				minx_q <= rd_x;
				maxx_q <= rd_x;
				miny_q <= rd_y;
				maxy_q <= rd_y;
			end else if (pos_s1 < n_p) begin
				if (rd_x < minx_q) minx_q <= rd_x;
				if (rd_x > maxx_q) maxx_q <= rd_x;
				if (rd_y < miny_q) miny_q <= rd_y;
				if (rd_y > maxy_q) maxy_q <= rd_y;
			end
		end
		if (load) begin
			rsp_q <= fin_load ? res_fin : res_imm;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(MAX_VERTICES))
		else $error("vertex count beyond table depth");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> req_stall)
		else $error("request taken while an operation is in progress");

	a_scale_wb_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (PW'(addr_s2) < n_p))
		else $error("scale write-back outside held vertices");

	a_fin_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && $past(state_q) != S_FIN) |-> !issue)
		else $error("read issued after operation finished");
`endif

endmodule

// File: rtl/cppt_vtx_mem.sv
module cppt_vtx_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int W     = 16
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic signed [W-1:0] wdata_x,
	input  logic signed [W-1:0] wdata_y,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output logic signed [W-1:0] rdata_x,
	output logic signed [W-1:0] rdata_y
);

	logic [2*W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wdata_x, wdata_y};
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_x <= $signed(mem[raddr][2*W-1:W]);
			rdata_y <= $signed(mem[raddr][W-1:0]);
		end
	end

endmodule

// File: rtl/cppt_cross.sv
module cppt_cross #(
	parameter int DW = 17
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     vld,
	input  logic                     last,
	input  logic signed [DW-1:0]     a,
	input  logic signed [DW-1:0]     b,
	input  logic signed [DW-1:0]     c,
	input  logic signed [DW-1:0]     d,
	output cppt_pkg::cross_flags_t   flags
);
	import cppt_pkg::*;

	localparam int MW = 2 * DW;

	logic                 vld_s1, last_s1, vld_s2, last_s2;
	logic signed [DW-1:0] a_s1, b_s1, c_s1, d_s1;
	logic signed [MW-1:0] m1_s2, m2_s2;
	cross_flags_t         flags_s3;

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			last_s1  <= 1'b0;
			vld_s2   <= 1'b0;
			last_s2  <= 1'b0;
			flags_s3 <= '0;
		end else begin
			vld_s1        <= vld;
			last_s1       <= vld & last;
			vld_s2        <= vld_s1;
			last_s2       <= last_s1;
			flags_s3.vld  <= vld_s2;
			flags_s3.last <= last_s2;
			flags_s3.pos  <= vld_s2 & (m1_s2 > m2_s2);
			flags_s3.neg  <= vld_s2 & (m1_s2 < m2_s2);
		end
	end

	// operand and product registers
	always_ff @(posedge clk) begin
		a_s1  <= a;
		b_s1  <= b;
		c_s1  <= c;
		d_s1  <= d;
		m1_s2 <= MW'(a_s1) * MW'(b_s1);
		m2_s2 <= MW'(c_s1) * MW'(d_s1);
	end

	assign flags = flags_s3;

endmodule
